### rtl/core/modexp_pkg.sv
`default_nettype none
package modexp_pkg;

	// Default word width of modulus, exponent and values
	localparam int WORD_BITS_DEF = 16;

	// Configuration register indexes
	typedef enum logic {
		REG_MODULUS  = 1'b0,
		REG_EXPONENT = 1'b1
	} reg_idx_t;

	// Control that travels with each item down the chain
	typedef struct packed {
		logic valid;
		logic last;
	} ctl_t;

endpackage
`default_nettype wire

### rtl/core/modexp_cell.sv
`default_nettype none
module modexp_cell #(
	parameter int W      = 16,
	parameter int BIT    = 0,  // multiplier bit handled by this cell
	parameter bit FINISH = 0,  // last step of a modular multiply
	parameter bit PRE    = 0   // input reduction cell (v mod n)
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            en,
	input  wire logic [W-1:0]    n,
	input  wire logic            ebit,
	input  wire modexp_pkg::ctl_t ctl_i,
	input  wire logic [W-1:0]    acc_i,
	input  wire logic [W-1:0]    sq_i,
	input  wire logic [W-1:0]    racc_i,
	input  wire logic [W-1:0]    rsq_i,
	output modexp_pkg::ctl_t     ctl_o,
	output logic [W-1:0]         acc_o,
	output logic [W-1:0]         sq_o,
	output logic [W-1:0]         racc_o,
	output logic [W-1:0]         rsq_o
);
	import modexp_pkg::*;

	// One step of interleaved modular multiply: r = (2r + b*a) mod n, with r, a < n
	function automatic logic [W-1:0] mstep(input logic [W-1:0] r, input logic b,
		input logic [W-1:0] a, input logic [W-1:0] m);
		logic [W+1:0] t;
		logic [W+1:0] m1;
		logic [W+1:0] m2;
		t  = {1'b0, r, 1'b0} + (b ? {2'b00, a} : '0);
		m1 = {2'b00, m};
		m2 = {1'b0, m, 1'b0};
		if (t >= m2) t = t - m2;
		else if (t >= m1) t = t - m1;
		return t[W-1:0];
	endfunction

	logic [W-1:0] racc_n, rsq_n;
	logic [W-1:0] acc_n, sq_n, racc_d, rsq_d;

	always_comb begin
		if (PRE) begin
			racc_n = racc_i;
			rsq_n  = mstep(rsq_i, sq_i[BIT], W'(1), n);
		end else begin
			racc_n = mstep(racc_i, acc_i[BIT], sq_i, n);
			rsq_n  = mstep(rsq_i, sq_i[BIT], sq_i, n);
		end
		if (FINISH) begin
			acc_n  = (!PRE && ebit) ? racc_n : acc_i;
			sq_n   = rsq_n;
			racc_d = '0;
			rsq_d  = '0;
		end else begin
			acc_n  = acc_i;
			sq_n   = sq_i;
			racc_d = racc_n;
			rsq_d  = rsq_n;
		end
	end

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_o <= '0;
		end else if (en) begin
			ctl_o <= ctl_i;
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		if (en) begin
			acc_o  <= acc_n;
			sq_o   <= sq_n;
			racc_o <= racc_d;
			rsq_o  <= rsq_d;
		end
	end

endmodule
`default_nettype wire

### rtl/core/modular_exponentiation.sv
// Modular exponentiation on a stream: each input value v gives v^exponent mod modulus.
// Input channel s_*: tdata holds value_in (low WORD_BITS bits), tuser holds in_last.
// Output channel m_*: tdata holds value_out, tuser holds out_last (copied through).
// Config port: cfg_we writes cfg_data to register cfg_addr (0 modulus, 1 exponent);
// write only while no items are in flight. Reset gives modulus 2, exponent 1.
// Structure: a chain of WORD_BITS + WORD_BITS^2 cells, each doing one shift-add-reduce
// step of a modular multiply; the first WORD_BITS cells reduce v mod n, then one group
// of WORD_BITS cells per exponent bit does square and conditional multiply together.
// Each result passes through the register of every cell in that chain, then the output register.
// Throughput: one item per cycle. When m_tready is low with a result waiting, the whole
// chain holds and s_tready drops; nothing is lost. Modulus below 2 gives 0.
// Reset clears all valid flags; data in flight is discarded.
`default_nettype none
module modular_exponentiation #(
	parameter int WORD_BITS = modexp_pkg::WORD_BITS_DEF,
	parameter int DATA_BITS = ((WORD_BITS + 7) / 8) * 8
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic                 cfg_addr,
	input  wire logic [WORD_BITS-1:0] cfg_data,
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	input  wire logic [DATA_BITS-1:0] s_tdata,  // value_in
	input  wire logic                 s_tuser,  // in_last
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	output logic [DATA_BITS-1:0]      m_tdata,  // value_out
	output logic                      m_tuser   // out_last
);
	import modexp_pkg::*;

	localparam int NCELL = WORD_BITS + WORD_BITS * WORD_BITS;

	logic [WORD_BITS-1:0] modulus_q, exponent_q;
	logic                 en;

	ctl_t                 ctl  [NCELL+1];
	logic [WORD_BITS-1:0] acc  [NCELL+1];
	logic [WORD_BITS-1:0] sq   [NCELL+1];
	logic [WORD_BITS-1:0] racc [NCELL+1];
	logic [WORD_BITS-1:0] rsq  [NCELL+1];

	logic                 out_valid_q, out_last_q;
	logic [WORD_BITS-1:0] out_value_q;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q  <= WORD_BITS'(2);
			exponent_q <= WORD_BITS'(1);
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_addr))
				REG_MODULUS:  modulus_q  <= cfg_data;
				REG_EXPONENT: exponent_q <= cfg_data;
				default:      ;
			endcase
		end
	end

	// Chain advances whenever the output slot is free or being taken
	assign en       = !out_valid_q || m_tready;
	assign s_tready = en;

	assign ctl[0].valid = s_tvalid;
	assign ctl[0].last  = s_tuser;
	assign acc[0]       = WORD_BITS'(1);
	assign sq[0]        = s_tdata[WORD_BITS-1:0];
	assign racc[0]      = '0;
	assign rsq[0]       = '0;

	// Cell chain
	for (genvar k = 0; k < NCELL; k++) begin : g_cell
		localparam bit PRE    = (k < WORD_BITS);
		localparam int M      = PRE ? 0 : k - WORD_BITS;
		localparam int STEP   = PRE ? k : M % WORD_BITS;
		localparam int EIDX   = PRE ? 0 : M / WORD_BITS;
		localparam bit FINISH = (STEP == WORD_BITS - 1);
		modexp_cell #(
			.W(WORD_BITS), .BIT(WORD_BITS - 1 - STEP), .FINISH(FINISH), .PRE(PRE)
		) u_cell (
			.clk(clk), .arst_n(arst_n), .en(en), .n(modulus_q),
			.ebit(exponent_q[EIDX]),
			.ctl_i(ctl[k]), .acc_i(acc[k]), .sq_i(sq[k]),
			.racc_i(racc[k]), .rsq_i(rsq[k]),
			.ctl_o(ctl[k+1]), .acc_o(acc[k+1]), .sq_o(sq[k+1]),
			.racc_o(racc[k+1]), .rsq_o(rsq[k+1])
		);
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= ctl[NCELL].valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_last_q  <= ctl[NCELL].last;
			out_value_q <= (modulus_q < WORD_BITS'(2)) ? '0 : acc[NCELL];
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = DATA_BITS'(out_value_q);
	assign m_tuser  = out_last_q;

	// Checks
	a_below_mod: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (modulus_q >= WORD_BITS'(2)) |-> (out_value_q < modulus_q))
		else $error("result not reduced below modulus");

	a_zero_exp: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (modulus_q >= WORD_BITS'(2)) && (exponent_q == '0)
		|-> (out_value_q == WORD_BITS'(1)))
		else $error("zero exponent must give 1");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		ctl[NCELL].valid && !en |=> ctl[NCELL].valid)
		else $error("chain item dropped during stall");

endmodule
`default_nettype wire

### bench/testbench.sv
`timescale 1ns / 1ps
`default_nettype none

// Scoreboard: predicts v^e mod n for each accepted value and checks results in order
class powmod_scoreboard;
	logic [15:0] modulus;
	logic [15:0] exponent;
	logic [15:0] value_queue[$];
	logic        last_queue[$];
	int          errors;
	int          checked;

	function new();
		modulus  = 16'd2;
		exponent = 16'd1;
		errors   = 0;
		checked  = 0;
	endfunction

	// square-and-multiply at double width
	function logic [15:0] power_mod(logic [15:0] base);
		logic [31:0] acc;
		logic [31:0] sq;
		if (modulus < 16'd2)
			return 16'd0;
		acc = 32'd1;
		sq  = {16'd0, base} % {16'd0, modulus};
		for (int b = 0; b < 16; b++) begin
			if (exponent[b])
				acc = (acc * sq) % {16'd0, modulus};
			sq = (sq * sq) % {16'd0, modulus};
		end
		return acc[15:0];
	endfunction

	function void note_input(logic [15:0] v, logic last);
		value_queue = {value_queue, power_mod(v)};
		last_queue  = {last_queue, last};
	endfunction

	function void check_result(logic [15:0] v, logic last);
		logic [15:0] ev;
		logic        el;
		if (value_queue.size() == 0) begin
			$error("unexpected result value_out=%0d out_last=%0d", v, last);
			errors++;
			return;
		end
		ev = value_queue.pop_front();
		el = last_queue.pop_front();
		checked++;
		if (v !== ev) begin
			$error("value_out expected %0d actual %0d", ev, v);
			errors++;
		end
		if (last !== el) begin
			$error("out_last expected %0d actual %0d", el, last);
			errors++;
		end
	endfunction

	function int pending();
		return value_queue.size();
	endfunction
endclass

module testbench;
	import modexp_pkg::*;

	localparam int LATENCY = 16 + 16 * 16 + 1;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic        cfg_addr;
	logic [15:0] cfg_data;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;
	logic        s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;
	logic        m_tuser;

	int send_idle_pct;
	int recv_idle_pct;
	int items_sent;

	powmod_scoreboard sb;

	modular_exponentiation uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// Receiver: random stalls, check on each accepted item
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tdata, m_tuser);
		m_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Send one value, with random idle cycles before it; tvalid stays high after accept
	task automatic send_value(input logic [15:0] v, input logic last);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= v;
		s_tuser  <= last;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sb.note_input(v, last);
		items_sent++;
	endtask

	// Wait until every expected result is in, then let the chain drain
	task automatic drain();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
	endtask

	// Write one register; the caller drops cfg_we afterwards
	task automatic write_reg(input reg_idx_t idx, input logic [15:0] val);
		cfg_we   <= 1'b1;
		cfg_addr <= idx;
		cfg_data <= val;
		@(posedge clk);
		if (idx == REG_MODULUS)
			sb.modulus = val;
		else
			sb.exponent = val;
	endtask

	task automatic set_key(input logic [15:0] n, input logic [15:0] e);
		write_reg(REG_MODULUS, n);
		write_reg(REG_EXPONENT, e);
		cfg_we <= 1'b0;
	endtask

	task automatic random_values(input int count);
		for (int i = 0; i < count; i++) begin
			case ($urandom_range(3))
				0: send_value(16'($urandom_range(255)), $urandom_range(7) == 0);
				1: send_value(16'(sb.modulus - 16'd1 + 16'($urandom_range(2))),
					1'($urandom_range(1)));
				default: send_value(16'($urandom_range(65535)), $urandom_range(7) == 0);
			endcase
		end
	endtask

	initial begin
		sb            = new();
		items_sent    = 0;
		send_idle_pct = 8;
		recv_idle_pct = 59;
		arst_n   = 1'b0;
		cfg_we   = 1'b0;
		cfg_addr = 1'b0;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = 1'b0;
		m_tready = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset key: n=2, e=1
		send_value(16'd0, 1'b0);
		send_value(16'd3, 1'b0);
		send_value(16'hFFFF, 1'b1);
		drain();

		// small textbook key n=3233, e=17, then d=2753
		set_key(16'd3233, 16'd17);
		send_value(16'd65, 1'b0);
		send_value(16'd0, 1'b0);
		send_value(16'd3232, 1'b0);
		send_value(16'd3233, 1'b0);
		send_value(16'hFFFF, 1'b1);
		drain();
		set_key(16'd3233, 16'd2753);
		send_value(16'd2790, 1'b1);
		send_value(16'd1, 1'b0);
		drain();

		// zero exponent, including 0^0
		set_key(16'd65535, 16'd0);
		send_value(16'd0, 1'b0);
		send_value(16'hFFFF, 1'b1);
		// largest exponent and modulus
		drain();
		set_key(16'd65535, 16'hFFFF);
		send_value(16'hFFFE, 1'b0);
		send_value(16'h5555, 1'b1);
		send_value(16'hAAAA, 1'b0);
		drain();
		// modulus below 2
		set_key(16'd1, 16'd7);
		send_value(16'd9, 1'b0);
		drain();
		set_key(16'd0, 16'd7);
		send_value(16'd9, 1'b1);
		drain();

		// random part, three idle profiles
		for (int ph = 0; ph < 3; ph++) begin
			send_idle_pct = (ph == 0) ? 8 : (ph == 1) ? 59 : 0;
			recv_idle_pct = (ph == 0) ? 59 : (ph == 1) ? 8 : 0;
			for (int k = 0; k < 4; k++) begin
				set_key(16'($urandom_range(65535, 2)), 16'($urandom_range(65535)));
				random_values(45);
				drain();
			end
		end
		set_key(16'd2, 16'd0);
		random_values(10);
		drain();

		$display("Covered %0d values (%0d checked) over many keys,", items_sent, sb.checked);
		$display("including zero exponent, tiny moduli and inputs past the modulus.");
		if (sb.errors == 0 && sb.pending() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	initial begin
		#20ms;
		$display("FAILURE");
		$finish;
	end
endmodule

`default_nettype wire

### filelist.f
rtl/core/modexp_pkg.sv
rtl/core/modexp_cell.sv
rtl/core/modular_exponentiation.sv
bench/testbench.sv
